/* hw/rtl/postfix_stack_evaluator_assert.svh */
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pse_pkg.sv */
// Types and constants of the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic [SYM_W-1:0] CH_0     = 8'h30;
	localparam logic [SYM_W-1:0] CH_9     = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WRITE,
		S_EMIT
	} state_t;

endpackage

/* hw/rtl/postfix_stack_evaluator.sv */
// Postfix stack evaluator: operand stack in a synchronous RAM with a cached top.
//
// Request channel (req_valid/req_ready) takes one word per character: symbol
// and end_of_expr. Response channel (rsp_valid/rsp_ready) gives one word,
// value and status, per expression, after its last character is processed.
// Words are taken one at a time: a digit or an ignored character is taken in
// idle; + - * add execute and write back after the read of the second entry;
// / adds execute and, for a nonzero divisor, a restoring divider (one quotient
// bit per cycle) and write back. A last character loads the response register.
// The top of stack lives in a register, so only the entry below it is read.
// Reset (arst_n low) empties the stack and clears the sticky error; the RAM
// itself is not cleared, since no entry is read before it is written.
// The response sits in an output register: the next expression's characters
// are taken while it waits. req_ready is low while an operator executes and
// while the response register is loaded; when a second response is due while
// the first is not taken, it stays low until the receiver takes the first.
`timescale 1ns / 1ps
module postfix_stack_evaluator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [pse_pkg::SYM_W-1:0]      symbol,
	input  logic                           end_of_expr,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic signed [pse_pkg::DATA_W-1:0] value,
	output logic [1:0]                     status
);

	pse_pkg::state_t state_q, state_d;

	logic [pse_pkg::CNT_W-1:0]  count_q;
	pse_pkg::status_t           err_q;
	logic [pse_pkg::DATA_W-1:0] top_q;
	logic [pse_pkg::DATA_W-1:0] rdata_q;
	logic [pse_pkg::DATA_W-1:0] res_q;
	pse_pkg::op_t               op_q;
	logic                       last_q;
	logic                       neg_q;
	logic [pse_pkg::DATA_W-1:0] rem_q;
	logic [pse_pkg::DATA_W-1:0] quo_q;
	logic [pse_pkg::DATA_W-1:0] dvs_q;
	logic [pse_pkg::STEP_W-1:0] step_q;
	logic                       rsp_valid_q;
	logic [pse_pkg::DATA_W-1:0] value_q;
	pse_pkg::status_t           status_q;

	logic [pse_pkg::DATA_W-1:0] mem [pse_pkg::STACK_DEPTH];

	logic                       accept;
	logic                       is_digit;
	logic                       is_op;
	pse_pkg::op_t               op_dec;
	logic                       full;
	logic                       few;
	logic [pse_pkg::CNT_W-1:0]  cnt_m2;
	logic                       mem_we;
	logic                       mem_re;
	logic [pse_pkg::ADDR_W-1:0] mem_waddr;
	logic [pse_pkg::DATA_W-1:0] mem_wdata;
	logic [pse_pkg::DATA_W-1:0] digit_val;
	logic [pse_pkg::DATA_W-1:0] wb_val;
	logic [pse_pkg::DATA_W-1:0] alu_res;
	logic [pse_pkg::DATA_W-1:0] lhs_mag;
	logic [pse_pkg::DATA_W-1:0] rhs_mag;
	logic [pse_pkg::DATA_W:0]   div_trial;
	logic [pse_pkg::DATA_W:0]   div_diff;
	logic                       div_bit;
	logic                       out_load;
	logic [pse_pkg::DATA_W-1:0] emit_value;
	pse_pkg::status_t           emit_status;

	// decode
	always_comb begin
		is_digit  = (symbol >= pse_pkg::CH_0) && (symbol <= pse_pkg::CH_9);
		is_op     = 1'b1;
		op_dec    = pse_pkg::OP_ADD;
		case (symbol)
			pse_pkg::CH_PLUS:  op_dec = pse_pkg::OP_ADD;
			pse_pkg::CH_MINUS: op_dec = pse_pkg::OP_SUB;
			pse_pkg::CH_STAR:  op_dec = pse_pkg::OP_MUL;
			pse_pkg::CH_SLASH: op_dec = pse_pkg::OP_DIV;
			default:           is_op  = 1'b0;
		endcase
		digit_val = {{(pse_pkg::DATA_W-4){1'b0}}, 4'(symbol - pse_pkg::CH_0)};
		full      = count_q >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH);
		few       = count_q < pse_pkg::CNT_W'(2);
		cnt_m2    = count_q - pse_pkg::CNT_W'(2);
		wb_val    = neg_q ? (~res_q + 1'b1) : res_q;
	end

	// execute
	always_comb begin
		lhs_mag = rdata_q[pse_pkg::DATA_W-1] ? (~rdata_q + 1'b1) : rdata_q;
		rhs_mag = top_q[pse_pkg::DATA_W-1] ? (~top_q + 1'b1) : top_q;
		case (op_q)
			pse_pkg::OP_ADD: alu_res = rdata_q + top_q;
			pse_pkg::OP_SUB: alu_res = rdata_q - top_q;
			pse_pkg::OP_MUL: alu_res = pse_pkg::DATA_W'(rdata_q * top_q);
			default:         alu_res = rdata_q;
		endcase
		div_trial = {rem_q, quo_q[pse_pkg::DATA_W-1]};
		div_diff  = div_trial - {1'b0, dvs_q};
		div_bit   = !div_diff[pse_pkg::DATA_W];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pse_pkg::S_IDLE: begin
				if (accept) begin
					if (err_q == pse_pkg::ST_OK && is_op && !few)
						state_d = pse_pkg::S_EXEC;
					else if (end_of_expr)
						state_d = pse_pkg::S_EMIT;
				end
			end
			pse_pkg::S_EXEC: begin
				if (op_q != pse_pkg::OP_DIV)
					state_d = pse_pkg::S_WRITE;
				else if (top_q == '0)
					state_d = last_q ? pse_pkg::S_EMIT : pse_pkg::S_IDLE;
				else
					state_d = pse_pkg::S_DIV;
			end
			pse_pkg::S_DIV: begin
				if (step_q == pse_pkg::STEP_W'(pse_pkg::DATA_W - 1))
					state_d = pse_pkg::S_WRITE;
			end
			pse_pkg::S_WRITE: state_d = last_q ? pse_pkg::S_EMIT : pse_pkg::S_IDLE;
			pse_pkg::S_EMIT: begin
				if (out_load)
					state_d = pse_pkg::S_IDLE;
			end
			default: state_d = pse_pkg::S_IDLE;
		endcase
	end

	// control
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = count_q[pse_pkg::ADDR_W-1:0];
		mem_wdata = digit_val;
		out_load  = 1'b0;
		case (state_q)
			pse_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && err_q == pse_pkg::ST_OK) begin
					mem_we = is_digit && !full;
					mem_re = is_op && !few;
				end
			end
			pse_pkg::S_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_m2[pse_pkg::ADDR_W-1:0];
				mem_wdata = wb_val;
			end
			pse_pkg::S_EMIT: out_load = !rsp_valid_q || rsp_ready;
			default: begin
				req_ready = 1'b0;
			end
		endcase
		accept = req_valid && req_ready;
		emit_status = err_q;
		emit_value  = '0;
		if (err_q == pse_pkg::ST_OK) begin
			if (count_q == '0)
				emit_status = pse_pkg::ST_UNDERFLOW;
			else
				emit_value = top_q;
		end
	end

	// stack RAM, second entry read at the operator word
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[cnt_m2[pse_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pse_pkg::S_IDLE;
			count_q     <= '0;
			err_q       <= pse_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				count_q <= '0;
				err_q   <= pse_pkg::ST_OK;
			end else if (accept && err_q == pse_pkg::ST_OK) begin
				if (is_digit) begin
					if (full)
						err_q <= pse_pkg::ST_OVERFLOW;
					else
						count_q <= count_q + 1'b1;
				end else if (is_op && few) begin
					err_q <= pse_pkg::ST_UNDERFLOW;
				end
			end else if (state_q == pse_pkg::S_EXEC && op_q == pse_pkg::OP_DIV
				&& top_q == '0) begin
				err_q <= pse_pkg::ST_DIVZERO;
			end else if (state_q == pse_pkg::S_WRITE) begin
				count_q <= count_q - 1'b1;
			end
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_dec;
			last_q <= end_of_expr;
			if (mem_we)
				top_q <= digit_val;
		end
		if (state_q == pse_pkg::S_EXEC) begin
			res_q  <= alu_res;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			quo_q  <= lhs_mag;
			dvs_q  <= rhs_mag;
			step_q <= '0;
			if (op_q == pse_pkg::OP_DIV)
				neg_q <= rdata_q[pse_pkg::DATA_W-1] ^ top_q[pse_pkg::DATA_W-1];
		end
		if (state_q == pse_pkg::S_DIV) begin
			rem_q  <= div_bit ? div_diff[pse_pkg::DATA_W-1:0]
				: div_trial[pse_pkg::DATA_W-1:0];
			quo_q  <= {quo_q[pse_pkg::DATA_W-2:0], div_bit};
			step_q <= step_q + 1'b1;
			res_q  <= {quo_q[pse_pkg::DATA_W-2:0], div_bit};
		end
		if (state_q == pse_pkg::S_WRITE)
			top_q <= wb_val;
		if (out_load) begin
			value_q  <= emit_value;
			status_q <= emit_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	`include "postfix_stack_evaluator_assert.svh"

	`PSE_ASSERT_NOW(a_count_range, 1'b1,
		count_q <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH), "stack count beyond depth")
	`PSE_ASSERT_NOW(a_div_operands, state_q == pse_pkg::S_DIV,
		count_q >= pse_pkg::CNT_W'(2) && err_q == pse_pkg::ST_OK, "divide without two operands")
	`PSE_ASSERT_NEXT(a_emit_clears, out_load,
		count_q == '0 && err_q == pse_pkg::ST_OK && rsp_valid, "stack not cleared at emit")
	`PSE_ASSERT_NEXT(a_err_sticky, err_q != pse_pkg::ST_OK && !out_load,
		$stable(count_q) && $stable(err_q), "stack changed under sticky error")

endmodule
